/* rtl/core/ptqg_pkg.sv */
// ----------------------------------------------------------------------------
// ptqg_pkg
// shared constants, types and helpers of the partial torus quad generator
// ----------------------------------------------------------------------------
package ptqg_pkg;

  localparam int INDEX_BITS_DEF    = 10;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;
  localparam int RAD_W     = 16;
  localparam int SPAN_W    = 17;
  localparam int ANG_W     = 16;
  localparam int TRIG_W    = 16;
  localparam int POS_W     = 18;
  localparam int CX_W      = 34;
  localparam int CZ_W      = 33;

  localparam logic [CFG_IDX_W-1:0] REG_MINOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAJOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RINGS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd5;

  localparam logic [1:0] TAG_TH0 = 2'd0;
  localparam logic [1:0] TAG_TH1 = 2'd1;
  localparam logic [1:0] TAG_PH0 = 2'd2;
  localparam logic [1:0] TAG_PH1 = 2'd3;

  localparam logic [31:0] CORDIC_X0 = 32'h26DD3B6A;

  localparam logic signed [63:0] UNIT    = 64'sd16384;
  localparam logic signed [63:0] NUNIT   = -64'sd16384;
  localparam logic signed [63:0] POS_MAX = 64'sd131071;
  localparam logic signed [63:0] POS_MIN = -64'sd131072;

  typedef struct packed {
    logic       valid;
    logic [1:0] tag;
    logic [1:0] quad;
  } ctl_t;

  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] a;
    case (k)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051D;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2E;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2F9;
      15: a = 32'h0000517C;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A2F;
      19: a = 32'h00000517;
      20: a = 32'h0000028B;
      21: a = 32'h00000145;
      22: a = 32'h000000A2;
      23: a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // round half up by a right shift, then clamp
  function automatic logic signed [63:0] sat_round(input logic signed [63:0] v,
                                                   input int sh,
                                                   input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (t < lo) begin
      t = lo;
    end else if (t > hi) begin
      t = hi;
    end
    return t;
  endfunction

endpackage

/* rtl/core/ptqg_div_cell.sv */
// ----------------------------------------------------------------------------
// ptqg_div_cell
// one restoring division step: one quotient bit per cell
// ----------------------------------------------------------------------------
module ptqg_div_cell #(
  parameter int IDX_W = ptqg_pkg::INDEX_BITS_DEF,
  parameter int DVD_W = ptqg_pkg::INDEX_BITS_DEF + 17
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ptqg_pkg::ctl_t                  ctl_i,
  input  logic [DVD_W-1:0]                dvd_i,
  input  logic [IDX_W-1:0]                dvs_i,
  input  logic [IDX_W-1:0]                rem_i,
  input  logic [ptqg_pkg::ANG_W-1:0]      quo_i,
  output ptqg_pkg::ctl_t                  ctl_o,
  output logic [DVD_W-1:0]                dvd_o,
  output logic [IDX_W-1:0]                dvs_o,
  output logic [IDX_W-1:0]                rem_o,
  output logic [ptqg_pkg::ANG_W-1:0]      quo_o
);

  ptqg_pkg::ctl_t                 ctl_r;
  logic [DVD_W-1:0]               dvd_r, dvd_nxt;
  logic [IDX_W-1:0]               dvs_r;
  logic [IDX_W-1:0]               rem_r, rem_nxt;
  logic [ptqg_pkg::ANG_W-1:0]     quo_r, quo_nxt;
  logic [IDX_W:0]                 trial;
  logic [IDX_W:0]                 diff;
  logic                           ge;

  always_comb begin
    trial   = {rem_i, dvd_i[DVD_W-1]};
    diff    = trial - {1'b0, dvs_i};
    ge      = (trial >= {1'b0, dvs_i});
    rem_nxt = ge ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
    dvd_nxt = {dvd_i[DVD_W-2:0], 1'b0};
    quo_nxt = {quo_i[ptqg_pkg::ANG_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_i;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign ctl_o = ctl_r;
  assign dvd_o = dvd_r;
  assign dvs_o = dvs_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

/* rtl/core/ptqg_cordic_cell.sv */
// ----------------------------------------------------------------------------
// ptqg_cordic_cell
// one rotation-mode cordic iteration with a fixed shift
// ----------------------------------------------------------------------------
module ptqg_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ptqg_pkg::ctl_t                       ctl_i,
  input  logic signed [ptqg_pkg::CX_W-1:0]     x_i,
  input  logic signed [ptqg_pkg::CX_W-1:0]     y_i,
  input  logic signed [ptqg_pkg::CZ_W-1:0]     z_i,
  output ptqg_pkg::ctl_t                       ctl_o,
  output logic signed [ptqg_pkg::CX_W-1:0]     x_o,
  output logic signed [ptqg_pkg::CX_W-1:0]     y_o,
  output logic signed [ptqg_pkg::CZ_W-1:0]     z_o
);

  ptqg_pkg::ctl_t                       ctl_r;
  logic signed [ptqg_pkg::CX_W-1:0]     x_r, x_nxt;
  logic signed [ptqg_pkg::CX_W-1:0]     y_r, y_nxt;
  logic signed [ptqg_pkg::CZ_W-1:0]     z_r, z_nxt;
  logic signed [ptqg_pkg::CX_W-1:0]     dx, dy;
  logic signed [ptqg_pkg::CZ_W-1:0]     at;

  always_comb begin
    dx = y_i >>> SHIFT;
    dy = x_i >>> SHIFT;
    at = $signed({{(ptqg_pkg::CZ_W-32){1'b0}}, ptqg_pkg::atan_turn(SHIFT)});
    if (!z_i[ptqg_pkg::CZ_W-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - at;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

/* rtl/core/ptqg_vertex.sv */
// ----------------------------------------------------------------------------
// ptqg_vertex
// gathers the four sine/cosine pairs of a quad and emits its four corners
// ----------------------------------------------------------------------------
module ptqg_vertex (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ptqg_pkg::ctl_t                         ctl_i,
  input  logic signed [ptqg_pkg::TRIG_W-1:0]     cos_i,
  input  logic signed [ptqg_pkg::TRIG_W-1:0]     sin_i,
  input  logic [ptqg_pkg::RAD_W-1:0]             minor_i,
  input  logic [ptqg_pkg::RAD_W-1:0]             major_i,
  output logic                                   out_valid,
  output logic [1:0]                             out_corner,
  output logic signed [ptqg_pkg::POS_W-1:0]      out_pos_x,
  output logic signed [ptqg_pkg::POS_W-1:0]      out_pos_y,
  output logic signed [ptqg_pkg::POS_W-1:0]      out_pos_z,
  output logic signed [ptqg_pkg::TRIG_W-1:0]     out_norm_x,
  output logic signed [ptqg_pkg::TRIG_W-1:0]     out_norm_y,
  output logic signed [ptqg_pkg::TRIG_W-1:0]     out_norm_z,
  output logic                                   out_last
);

  localparam int TW = ptqg_pkg::TRIG_W;

  logic signed [TW-1:0] ct0_r, st0_r, ct1_r, st1_r, cp0_r, sp0_r;
  logic signed [TW-1:0] h_ct0_r, h_st0_r, h_ct1_r, h_st1_r;
  logic signed [TW-1:0] h_cp0_r, h_sp0_r, h_cp1_r, h_sp1_r;
  logic                 cn_act_r, cn_act_nxt;
  logic [1:0]           cn_r, cn_nxt;
  logic                 load;

  logic                 t_sel, p_sel;
  logic signed [TW-1:0] ct, st, cp, sp;
  logic signed [TW:0]   nst;
  logic signed [TW:0]   msig;
  logic signed [32:0]   rcp, rsp, nyp;
  logic signed [31:0]   nxp;
  logic signed [33:0]   rho;

  logic                 a_val_r;
  logic [1:0]           a_cn_r;
  logic signed [TW-1:0] a_ct_r, a_nz_r;
  logic signed [TW:0]   a_nst_r;
  logic signed [33:0]   a_rho_r;
  logic signed [32:0]   a_pz_r, a_ny_r;
  logic signed [31:0]   a_nx_r;

  logic                 b_val_r;
  logic [1:0]           b_cn_r;
  logic signed [49:0]   b_px_r;
  logic signed [50:0]   b_py_r;
  logic signed [32:0]   b_pz_r, b_ny_r;
  logic signed [31:0]   b_nx_r;
  logic signed [TW-1:0] b_nz_r;

  logic signed [63:0]   px_w, py_w, pz_w, nx_w, ny_w;

  logic                 o_val_r;
  logic [1:0]           o_cn_r;
  logic signed [ptqg_pkg::POS_W-1:0] o_px_r, o_py_r, o_pz_r;
  logic signed [TW-1:0] o_nx_r, o_ny_r, o_nz_r;

  assign load = ctl_i.valid && (ctl_i.tag == ptqg_pkg::TAG_PH1);

  always_ff @(posedge clk) begin
    if (ctl_i.valid) begin
      case (ctl_i.tag)
        ptqg_pkg::TAG_TH0: begin
          ct0_r <= cos_i;
          st0_r <= sin_i;
        end
        ptqg_pkg::TAG_TH1: begin
          ct1_r <= cos_i;
          st1_r <= sin_i;
        end
        ptqg_pkg::TAG_PH0: begin
          cp0_r <= cos_i;
          sp0_r <= sin_i;
        end
        default: begin
        end
      endcase
    end
    if (load) begin
      h_ct0_r <= ct0_r;
      h_st0_r <= st0_r;
      h_ct1_r <= ct1_r;
      h_st1_r <= st1_r;
      h_cp0_r <= cp0_r;
      h_sp0_r <= sp0_r;
      h_cp1_r <= cos_i;
      h_sp1_r <= sin_i;
    end
  end

  // corner sequencer
  always_comb begin
    cn_act_nxt = cn_act_r;
    cn_nxt     = cn_r;
    if (load) begin
      cn_act_nxt = 1'b1;
      cn_nxt     = 2'd0;
    end else if (cn_act_r) begin
      cn_nxt = cn_r + 2'd1;
      if (cn_r == 2'd3) begin
        cn_act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cn_act_r <= 1'b0;
      cn_r     <= 2'd0;
      a_val_r  <= 1'b0;
      b_val_r  <= 1'b0;
      o_val_r  <= 1'b0;
    end else begin
      cn_act_r <= cn_act_nxt;
      cn_r     <= cn_nxt;
      a_val_r  <= cn_act_r;
      b_val_r  <= a_val_r;
      o_val_r  <= b_val_r;
    end
  end

  // stage a: corner select, radius and normal products
  always_comb begin
    t_sel = cn_r[0] ^ cn_r[1];
    p_sel = ~cn_r[1];
    ct    = t_sel ? h_ct1_r : h_ct0_r;
    st    = t_sel ? h_st1_r : h_st0_r;
    cp    = p_sel ? h_cp1_r : h_cp0_r;
    sp    = p_sel ? h_sp1_r : h_sp0_r;
    nst   = -(17'(st));
    msig  = $signed({1'b0, minor_i});
    rcp   = msig * cp;
    rsp   = msig * sp;
    nxp   = ct * cp;
    nyp   = nst * cp;
    rho   = 34'($signed({2'b00, major_i, 14'b0})) + 34'(rcp);
  end

  always_ff @(posedge clk) begin
    a_cn_r  <= cn_r;
    a_ct_r  <= ct;
    a_nst_r <= nst;
    a_rho_r <= rho;
    a_pz_r  <= rsp;
    a_nx_r  <= nxp;
    a_ny_r  <= nyp;
    a_nz_r  <= sp;
  end

  // stage b: position products
  always_ff @(posedge clk) begin
    b_cn_r <= a_cn_r;
    b_px_r <= a_ct_r * a_rho_r;
    b_py_r <= a_nst_r * a_rho_r;
    b_pz_r <= a_pz_r;
    b_nx_r <= a_nx_r;
    b_ny_r <= a_ny_r;
    b_nz_r <= a_nz_r;
  end

  // stage c: round and saturate
  always_comb begin
    px_w = ptqg_pkg::sat_round(64'(b_px_r), 28, ptqg_pkg::POS_MIN, ptqg_pkg::POS_MAX);
    py_w = ptqg_pkg::sat_round(64'(b_py_r), 28, ptqg_pkg::POS_MIN, ptqg_pkg::POS_MAX);
    pz_w = ptqg_pkg::sat_round(64'(b_pz_r), 14, ptqg_pkg::POS_MIN, ptqg_pkg::POS_MAX);
    nx_w = ptqg_pkg::sat_round(64'(b_nx_r), 14, ptqg_pkg::NUNIT, ptqg_pkg::UNIT);
    ny_w = ptqg_pkg::sat_round(64'(b_ny_r), 14, ptqg_pkg::NUNIT, ptqg_pkg::UNIT);
  end

  always_ff @(posedge clk) begin
    o_cn_r <= b_cn_r;
    o_px_r <= px_w[ptqg_pkg::POS_W-1:0];
    o_py_r <= py_w[ptqg_pkg::POS_W-1:0];
    o_pz_r <= pz_w[ptqg_pkg::POS_W-1:0];
    o_nx_r <= nx_w[TW-1:0];
    o_ny_r <= ny_w[TW-1:0];
    o_nz_r <= b_nz_r;
  end

  assign out_valid  = o_val_r;
  assign out_corner = o_cn_r;
  assign out_pos_x  = o_px_r;
  assign out_pos_y  = o_py_r;
  assign out_pos_z  = o_pz_r;
  assign out_norm_x = o_nx_r;
  assign out_norm_y = o_ny_r;
  assign out_norm_z = o_nz_r;
  assign out_last   = (o_cn_r == 2'd3);

endmodule

/* rtl/core/partial_torus_quad_generator.sv */
// ----------------------------------------------------------------------------
// partial_torus_quad_generator
// emits the four corners of one torus quad with position and unit normal
//
//   channel  ports                               handshake
//   input    in_ring_index, in_side_index        start while busy low
//   result   out_corner .. out_last              out_valid, one cycle each
//   config   cfg_index, cfg_data                 cfg_we
//
// the four angle divisions and the four sine/cosine evaluations of a quad share
// one divider chain and one cordic chain, one word a cycle; a new start is
// taken while the last word of the previous quad is fed. a quad then passes
// the index, feed, divider, angle, cordic and trig registers, the corner sequencer
// and vertex stages a, b, c. reset clears all valid flags, loads register defaults.
// ----------------------------------------------------------------------------
module partial_torus_quad_generator #(
  parameter int INDEX_BITS    = ptqg_pkg::INDEX_BITS_DEF,
  parameter int CORDIC_STAGES = ptqg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [INDEX_BITS-1:0]                  in_ring_index,
  input  logic [INDEX_BITS-1:0]                  in_side_index,
  input  logic                                   cfg_we,
  input  logic [ptqg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ptqg_pkg::CFG_W-1:0]             cfg_data,
  output logic                                   out_valid,
  output logic [1:0]                             out_corner,
  output logic signed [ptqg_pkg::POS_W-1:0]      out_pos_x,
  output logic signed [ptqg_pkg::POS_W-1:0]      out_pos_y,
  output logic signed [ptqg_pkg::POS_W-1:0]      out_pos_z,
  output logic signed [ptqg_pkg::TRIG_W-1:0]     out_norm_x,
  output logic signed [ptqg_pkg::TRIG_W-1:0]     out_norm_y,
  output logic signed [ptqg_pkg::TRIG_W-1:0]     out_norm_z,
  output logic                                   out_last
);

  localparam int IW    = INDEX_BITS;
  localparam int DVD_W = INDEX_BITS + 17;
  localparam int AW    = ptqg_pkg::ANG_W;
  localparam int CXW   = ptqg_pkg::CX_W;
  localparam int CZW   = ptqg_pkg::CZ_W;
  localparam int TW    = ptqg_pkg::TRIG_W;

  logic [ptqg_pkg::RAD_W-1:0]  minor_r, major_r;
  logic [IW-1:0]               sides_r, rings_r;
  logic [ptqg_pkg::SPAN_W-1:0] span_r;
  logic [AW-1:0]               offset_r;

  logic [IW-1:0]   ri_r, si_r;
  logic            feed_act_r, feed_act_nxt;
  logic [1:0]      feed_cnt_r, feed_cnt_nxt;
  logic            accept;

  logic [IW-1:0]   base;
  logic [IW:0]     base1;
  logic [IW+17:0]  prod;
  logic [IW-1:0]   dvs_sel;
  logic [DVD_W-1:0] dvd_sel;

  ptqg_pkg::ctl_t  f_ctl_r;
  logic [DVD_W-1:0] f_dvd_r;
  logic [IW-1:0]   f_dvs_r;

  ptqg_pkg::ctl_t  d_ctl [0:DVD_W];
  logic [DVD_W-1:0] d_dvd [0:DVD_W];
  logic [IW-1:0]   d_dvs [0:DVD_W];
  logic [IW-1:0]   d_rem [0:DVD_W];
  logic [AW-1:0]   d_quo [0:DVD_W];

  ptqg_pkg::ctl_t  g_ctl_r;
  logic [AW-1:0]   g_ang_r, g_ang_nxt;

  ptqg_pkg::ctl_t        c_ctl [0:CORDIC_STAGES];
  logic signed [CXW-1:0] c_x   [0:CORDIC_STAGES];
  logic signed [CXW-1:0] c_y   [0:CORDIC_STAGES];
  logic signed [CZW-1:0] c_z   [0:CORDIC_STAGES];

  logic signed [63:0]    xr, yr;
  logic signed [TW-1:0]  xc, yc, cos_nxt, sin_nxt;
  ptqg_pkg::ctl_t        t_ctl_r;
  logic signed [TW-1:0]  t_cos_r, t_sin_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minor_r  <= 16'd256;
      major_r  <= 16'd512;
      sides_r  <= IW'(4);
      rings_r  <= IW'(8);
      span_r   <= 17'h10000;
      offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ptqg_pkg::REG_MINOR:  minor_r  <= cfg_data[ptqg_pkg::RAD_W-1:0];
        ptqg_pkg::REG_MAJOR:  major_r  <= cfg_data[ptqg_pkg::RAD_W-1:0];
        ptqg_pkg::REG_SIDES:  sides_r  <= cfg_data[IW-1:0];
        ptqg_pkg::REG_RINGS:  rings_r  <= cfg_data[IW-1:0];
        ptqg_pkg::REG_SPAN:   span_r   <= cfg_data[ptqg_pkg::SPAN_W-1:0];
        ptqg_pkg::REG_OFFSET: offset_r <= cfg_data[AW-1:0];
        default: begin
        end
      endcase
    end
  end

  // feed: four division words per quad
  assign busy   = feed_act_r && (feed_cnt_r != 2'd3);
  assign accept = start && !busy;

  always_comb begin
    feed_act_nxt = feed_act_r;
    feed_cnt_nxt = feed_cnt_r;
    if (accept) begin
      feed_act_nxt = 1'b1;
      feed_cnt_nxt = 2'd0;
    end else if (feed_act_r) begin
      feed_cnt_nxt = feed_cnt_r + 2'd1;
      if (feed_cnt_r == 2'd3) begin
        feed_act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed_act_r <= 1'b0;
      feed_cnt_r <= 2'd0;
      f_ctl_r    <= '0;
    end else begin
      feed_act_r <= feed_act_nxt;
      feed_cnt_r <= feed_cnt_nxt;
      f_ctl_r    <= '{valid: feed_act_r, tag: feed_cnt_r, quad: 2'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ri_r <= in_ring_index;
      si_r <= in_side_index;
    end
  end

  always_comb begin
    base  = feed_cnt_r[1] ? si_r : ri_r;
    base1 = {1'b0, base} + (IW+1)'(feed_cnt_r[0]);
    prod  = (IW+18)'(base1) * (IW+18)'(span_r);
    if (feed_cnt_r[1]) begin
      dvd_sel = {base1, 16'b0};
      dvs_sel = (sides_r == '0) ? IW'(1) : sides_r;
    end else begin
      dvd_sel = prod[DVD_W-1:0];
      dvs_sel = (rings_r == '0) ? IW'(1) : rings_r;
    end
  end

  always_ff @(posedge clk) begin
    f_dvd_r <= dvd_sel;
    f_dvs_r <= dvs_sel;
  end

  // divider chain
  assign d_ctl[0] = f_ctl_r;
  assign d_dvd[0] = f_dvd_r;
  assign d_dvs[0] = f_dvs_r;
  assign d_rem[0] = '0;
  assign d_quo[0] = '0;

  for (genvar k = 0; k < DVD_W; k++) begin : g_div
    ptqg_div_cell #(
      .IDX_W (IW),
      .DVD_W (DVD_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (d_ctl[k]),
      .dvd_i (d_dvd[k]),
      .dvs_i (d_dvs[k]),
      .rem_i (d_rem[k]),
      .quo_i (d_quo[k]),
      .ctl_o (d_ctl[k+1]),
      .dvd_o (d_dvd[k+1]),
      .dvs_o (d_dvs[k+1]),
      .rem_o (d_rem[k+1]),
      .quo_o (d_quo[k+1])
    );
  end

  // angle
  assign g_ang_nxt = d_quo[DVD_W] + (d_ctl[DVD_W].tag[1] ? '0 : offset_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_ctl_r <= '0;
    end else begin
      g_ctl_r <= '{valid: d_ctl[DVD_W].valid, tag: d_ctl[DVD_W].tag,
                   quad: g_ang_nxt[AW-1:AW-2]};
    end
  end

  always_ff @(posedge clk) begin
    g_ang_r <= g_ang_nxt;
  end

  // cordic chain
  assign c_ctl[0] = g_ctl_r;
  assign c_x[0]   = $signed(CXW'(ptqg_pkg::CORDIC_X0));
  assign c_y[0]   = '0;
  assign c_z[0]   = $signed(CZW'({g_ang_r[AW-3:0], 16'b0}));

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    ptqg_cordic_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (c_ctl[k]),
      .x_i   (c_x[k]),
      .y_i   (c_y[k]),
      .z_i   (c_z[k]),
      .ctl_o (c_ctl[k+1]),
      .x_o   (c_x[k+1]),
      .y_o   (c_y[k+1]),
      .z_o   (c_z[k+1])
    );
  end

  // round, clamp and quadrant fold
  always_comb begin
    xr = ptqg_pkg::sat_round(64'(c_x[CORDIC_STAGES]), 16, ptqg_pkg::NUNIT, ptqg_pkg::UNIT);
    yr = ptqg_pkg::sat_round(64'(c_y[CORDIC_STAGES]), 16, ptqg_pkg::NUNIT, ptqg_pkg::UNIT);
    xc = xr[TW-1:0];
    yc = yr[TW-1:0];
    case (c_ctl[CORDIC_STAGES].quad)
      2'd0: begin
        cos_nxt = xc;
        sin_nxt = yc;
      end
      2'd1: begin
        cos_nxt = -yc;
        sin_nxt = xc;
      end
      2'd2: begin
        cos_nxt = -xc;
        sin_nxt = -yc;
      end
      default: begin
        cos_nxt = yc;
        sin_nxt = -xc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_ctl_r <= '0;
    end else begin
      t_ctl_r <= c_ctl[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    t_cos_r <= cos_nxt;
    t_sin_r <= sin_nxt;
  end

  ptqg_vertex u_vertex (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (t_ctl_r),
    .cos_i      (t_cos_r),
    .sin_i      (t_sin_r),
    .minor_i    (minor_r),
    .major_i    (major_r),
    .out_valid  (out_valid),
    .out_corner (out_corner),
    .out_pos_x  (out_pos_x),
    .out_pos_y  (out_pos_y),
    .out_pos_z  (out_pos_z),
    .out_norm_x (out_norm_x),
    .out_norm_y (out_norm_y),
    .out_norm_z (out_norm_z),
    .out_last   (out_last)
  );

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// partial torus quad generator testbench: quads are driven through the start
// handshake under random gaps, corners are predicted by a local cordic and
// fixed-point model and compared field by field in arrival order
// ----------------------------------------------------------------------------
module tb;

  localparam int IB  = 10;
  localparam int STG = 16;
  localparam int LAT = IB + STG + 40;

  typedef struct packed {
    logic [IB-1:0] ring;
    logic [IB-1:0] side;
  } quad_req_t;

  typedef struct {
    logic [1:0]                  corner;
    logic [ptqg_pkg::POS_W-1:0]  px, py, pz;
    logic [ptqg_pkg::TRIG_W-1:0] nx, ny, nz;
    logic                        last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [IB-1:0] in_ring_index = '0;
  logic [IB-1:0] in_side_index = '0;
  logic cfg_we = 1'b0;
  logic [ptqg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ptqg_pkg::CFG_W-1:0] cfg_data = '0;
  logic out_valid, out_last;
  logic [1:0] out_corner;
  logic signed [ptqg_pkg::POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [ptqg_pkg::TRIG_W-1:0] out_norm_x, out_norm_y, out_norm_z;

  partial_torus_quad_generator #(.INDEX_BITS(IB), .CORDIC_STAGES(STG)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_ring_index(in_ring_index), .in_side_index(in_side_index),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_corner(out_corner),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_norm_x(out_norm_x), .out_norm_y(out_norm_y), .out_norm_z(out_norm_z),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  quad_req_t pending_quads[$];
  vertex_t   expected_corners[$];
  int errors = 0;
  int quads_sent = 0;
  int quads_issued = 0;
  int corners_seen = 0;
  int idle_pct = 32;

  // register copy
  logic [15:0] minor_r = 16'd256, major_r = 16'd512, offs = 16'd0;
  logic [IB-1:0] sides_n = 4, rings_n = 8;
  logic [16:0] span_t = 17'd65536;

  function automatic longint fshift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint rnd_clamp(longint v, int k, longint lo, longint hi);
    longint t;
    t = (v + (64'sd1 <<< (k - 1))) >>> k;
    return t < lo ? lo : (t > hi ? hi : t);
  endfunction

  function automatic void trig(logic [15:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy, at;
    logic [1:0] q;
    q = ang[15:14];
    z = longint'({ang[13:0], 16'h0});
    x = longint'(ptqg_pkg::CORDIC_X0);
    y = 0;
    for (int k = 0; k < STG; k++) begin
      dx = fshift(y, k);
      dy = fshift(x, k);
      at = longint'(ptqg_pkg::atan_turn(k));
      if (z >= 0) begin
        x -= dx; y += dy; z -= at;
      end else begin
        x += dx; y -= dy; z += at;
      end
    end
    x = rnd_clamp(x, 16, -16384, 16384);
    y = rnd_clamp(y, 16, -16384, 16384);
    case (q)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  task automatic predict_quad(quad_req_t r);
    longint rings, sides, ii, jj, ct[2], st[2], cp[2], sp[2], rho;
    logic [15:0] th[2], ph[2];
    int ts, ps;
    vertex_t v;
    rings = (rings_n == 0) ? 1 : rings_n;
    sides = (sides_n == 0) ? 1 : sides_n;
    ii = r.ring;
    jj = r.side;
    th[0] = 16'(offs + (ii * span_t) / rings);
    th[1] = 16'(offs + ((ii + 1) * span_t) / rings);
    ph[0] = 16'((jj << 16) / sides);
    ph[1] = 16'(((jj + 1) << 16) / sides);
    for (int k = 0; k < 2; k++) begin
      trig(th[k], ct[k], st[k]);
      trig(ph[k], cp[k], sp[k]);
    end
    for (int k = 0; k < 4; k++) begin
      ts = (k == 1 || k == 2) ? 1 : 0;
      ps = (k < 2) ? 1 : 0;
      rho = (longint'(major_r) <<< 14) + longint'(minor_r) * cp[ps];
      v.corner = 2'(k);
      v.px = ptqg_pkg::POS_W'(rnd_clamp(ct[ts] * rho, 28, -131072, 131071));
      v.py = ptqg_pkg::POS_W'(rnd_clamp(-st[ts] * rho, 28, -131072, 131071));
      v.pz = ptqg_pkg::POS_W'(rnd_clamp(longint'(minor_r) * sp[ps], 14, -131072, 131071));
      v.nx = ptqg_pkg::TRIG_W'(rnd_clamp(ct[ts] * cp[ps], 14, -16384, 16384));
      v.ny = ptqg_pkg::TRIG_W'(rnd_clamp(-st[ts] * cp[ps], 14, -16384, 16384));
      v.nz = ptqg_pkg::TRIG_W'(sp[ps]);
      v.last = (k == 3);
      expected_corners.push_back(v);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (start && !busy) begin
      predict_quad('{ring: in_ring_index, side: in_side_index});
      quads_sent++;
    end
  end

  always @(negedge clk) begin
    if (rst_n && !(start && quads_issued != quads_sent)) begin
      if (pending_quads.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_ring_index <= pending_quads[0].ring;
        in_side_index <= pending_quads[0].side;
        void'(pending_quads.pop_front());
        quads_issued++;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_valid) begin
      corners_seen++;
      if (expected_corners.size() == 0) begin
        errors++;
        $display("%0t unexpected word corner %0d", $time, out_corner);
      end else begin
        e = expected_corners.pop_front();
        if (e.corner !== out_corner || e.px !== out_pos_x || e.py !== out_pos_y ||
            e.pz !== out_pos_z || e.nx !== out_norm_x || e.ny !== out_norm_y ||
            e.nz !== out_norm_z || e.last !== out_last) begin
          errors++;
          $display("%0t mismatch exp c%0d p(%0d %0d %0d) n(%0d %0d %0d) l%0b", $time,
                   e.corner, $signed(e.px), $signed(e.py), $signed(e.pz),
                   $signed(e.nx), $signed(e.ny), $signed(e.nz), e.last);
          $display("%0t          act c%0d p(%0d %0d %0d) n(%0d %0d %0d) l%0b", $time,
                   out_corner, out_pos_x, out_pos_y, out_pos_z,
                   out_norm_x, out_norm_y, out_norm_z, out_last);
        end
      end
    end
  end

  task automatic write_reg(logic [ptqg_pkg::CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= ptqg_pkg::CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ptqg_pkg::REG_MINOR:  minor_r = val[15:0];
      ptqg_pkg::REG_MAJOR:  major_r = val[15:0];
      ptqg_pkg::REG_SIDES:  sides_n = val[IB-1:0];
      ptqg_pkg::REG_RINGS:  rings_n = val[IB-1:0];
      ptqg_pkg::REG_SPAN:   span_t = val[16:0];
      ptqg_pkg::REG_OFFSET: offs = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_quads.size() > 0 || start || expected_corners.size() > 0)
      @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  function automatic quad_req_t rand_quad(int rmax, int smax);
    quad_req_t q;
    q.ring = IB'($urandom_range(rmax));
    q.side = IB'($urandom_range(smax));
    return q;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed at reset defaults
    pending_quads.push_back('{ring: 0, side: 0});
    pending_quads.push_back('{ring: 7, side: 3});
    pending_quads.push_back('{ring: 1023, side: 1023});
    pending_quads.push_back('{ring: 8, side: 4});
    pending_quads.push_back('{ring: 512, side: 341});
    drain();
    // zero counts, unknown register, wrapping span
    write_reg(ptqg_pkg::REG_SIDES, 0);
    write_reg(ptqg_pkg::REG_RINGS, 0);
    write_reg(3'd7, 17'h1ffff);
    pending_quads.push_back('{ring: 0, side: 0});
    pending_quads.push_back('{ring: 1023, side: 1023});
    drain();
    write_reg(ptqg_pkg::REG_MINOR, 16'hffff);
    write_reg(ptqg_pkg::REG_MAJOR, 16'hffff);
    write_reg(ptqg_pkg::REG_SIDES, 1023);
    write_reg(ptqg_pkg::REG_RINGS, 1023);
    write_reg(ptqg_pkg::REG_SPAN, 17'h1ffff);
    write_reg(ptqg_pkg::REG_OFFSET, 16'hffff);
    pending_quads.push_back('{ring: 0, side: 0});
    pending_quads.push_back('{ring: 1023, side: 1023});
    pending_quads.push_back('{ring: 255, side: 767});
    pending_quads.push_back('{ring: 682, side: 341});
    drain();
    write_reg(ptqg_pkg::REG_MINOR, 0);
    write_reg(ptqg_pkg::REG_MAJOR, 0);
    write_reg(ptqg_pkg::REG_SPAN, 0);
    write_reg(ptqg_pkg::REG_OFFSET, 0);
    pending_quads.push_back('{ring: 100, side: 200});
    pending_quads.push_back('{ring: 1023, side: 0});
    drain();
    // random phases with random settings; one without idling
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(ptqg_pkg::REG_MINOR, $urandom_range(16'hffff));
      write_reg(ptqg_pkg::REG_MAJOR,
                (ph % 2) ? $urandom_range(16'h1000) : $urandom_range(16'hffff));
      write_reg(ptqg_pkg::REG_SIDES, $urandom_range(1023));
      write_reg(ptqg_pkg::REG_RINGS, $urandom_range(1023));
      write_reg(ptqg_pkg::REG_SPAN, $urandom_range(17'h1ffff));
      write_reg(ptqg_pkg::REG_OFFSET, $urandom_range(16'hffff));
      idle_pct = (ph == 3) ? 0 : 32;
      for (int n = 0; n < 24; n++)
        pending_quads.push_back(rand_quad(n % 3 == 0 ? 1023 : rings_n, 1023));
      drain();
    end
    $display("%0d quads sent, %0d corners checked across extremes and random settings",
             quads_sent, corners_seen);
    if (errors == 0) begin
      $display("[partial_torus_quad_generator] OK");
    end else begin
      $display("[partial_torus_quad_generator] ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[partial_torus_quad_generator] ERROR");
    $finish;
  end

endmodule
